@@ rtl/core/mspt_pkg.sv @@
// Shared types, codes and constants of the multi-slot periodic timer.
package mspt_pkg;

  localparam int TIME_W        = 48;
  localparam int PER_W         = 16;
  localparam int IDX_W         = 32;
  localparam int DL_W          = TIME_W + 1;
  localparam int SLOT_W        = 3;
  localparam int SLOTS_DEF     = 8;
  localparam int QDEPTH        = 2;
  localparam logic [PER_W-1:0] MAX_SLEEP_RST = 16'd200;

  // Request codes as they arrive on the input channel.
  localparam logic [1:0] REQ_REG   = 2'd0;
  localparam logic [1:0] REQ_UNREG = 2'd1;
  localparam logic [1:0] REQ_POLL  = 2'd2;

  typedef enum logic [1:0] {
    OP_REG,
    OP_UNREG,
    OP_POLL
  } cmd_op_t;

  typedef enum logic [1:0] {
    EV_REG,
    EV_UNREG,
    EV_FIRE,
    EV_SLEEP
  } evt_kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REG,
    ST_UNREG_RD,
    ST_UNREG_CHK,
    ST_POLL_RD,
    ST_POLL_CHK,
    ST_POLL_DIV,
    ST_POLL_FIRE,
    ST_SUMMARY
  } back_state_t;

  typedef struct packed {
    cmd_op_t           op;
    logic [SLOT_W-1:0] slot;
    logic [PER_W-1:0]  period;
    logic [TIME_W-1:0] now;
  } cmd_t;

  typedef struct packed {
    logic [TIME_W-1:0] start;
    logic [PER_W-1:0]  period;
    logic [IDX_W-1:0]  index;
    logic [DL_W-1:0]   deadline;
    logic [TIME_W-1:0] prev_fire;
  } ent_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    evt_kind_t         kind;
    logic [TIME_W-1:0] ev_time;
    logic [TIME_W-1:0] elapsed;
    logic [PER_W-1:0]  sleep_ms;
    logic              last;
  } evt_t;

endpackage

@@ rtl/core/mspt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module mspt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/mspt_div.sv @@
// Restoring divider, one quotient bit per cycle, for the catch-up computation.
module mspt_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [mspt_pkg::TIME_W-1:0] dividend,
  input  logic [mspt_pkg::PER_W-1:0]  divisor,
  output logic                       done,
  output logic [mspt_pkg::TIME_W-1:0] quot,
  output logic [mspt_pkg::PER_W-1:0]  rem
);
  import mspt_pkg::*;

  localparam int CNT_W = $clog2(TIME_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [TIME_W-1:0] q_r, q_nxt;
  logic [PER_W-1:0]  rem_r, rem_nxt;
  logic [PER_W-1:0]  dvs_r, dvs_nxt;
  logic [PER_W:0]    rem_sh;
  logic              ge;

  always_comb begin
    rem_sh   = {rem_r, q_r[TIME_W-1]};
    ge       = rem_sh >= {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      q_nxt   = {q_r[TIME_W-2:0], ge};
      rem_nxt = ge ? PER_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[PER_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(TIME_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = rem_r;

endmodule

@@ rtl/core/mspt_fifo.sv @@
// Short command queue between the request front end and the slot engine.
module mspt_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mspt_pkg::cmd_t push_data,
  input  logic           pop,
  output mspt_pkg::cmd_t head,
  output logic           full,
  output logic           empty
);
  import mspt_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  cmd_t          mem_r [QDEPTH];
  logic [PW-1:0] wr_r, wr_nxt;
  logic [PW-1:0] rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = cnt_r == CW'(QDEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == PW'(QDEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PW'(QDEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_data;
    end
  end

endmodule

@@ rtl/core/mspt_front.sv @@
// Request front end: accepts input transactions and turns them into commands.
module mspt_front #(
  parameter int SLOTS = mspt_pkg::SLOTS_DEF
) (
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_req_type,
  input  logic [mspt_pkg::SLOT_W-1:0] in_slot,
  input  logic [mspt_pkg::PER_W-1:0]  in_period,
  input  logic [mspt_pkg::TIME_W-1:0] in_now,
  input  logic                        q_full,
  output logic                        q_push,
  output mspt_pkg::cmd_t              q_data
);
  import mspt_pkg::*;

  logic slot_ok;
  logic keep;

  assign slot_ok  = 32'(in_slot) < 32'(SLOTS);
  assign in_stall = q_full;

  always_comb begin
    keep          = 1'b0;
    q_data.op     = OP_POLL;
    q_data.slot   = in_slot;
    q_data.period = (in_period == '0) ? PER_W'(1) : in_period;
    q_data.now    = in_now;
    case (in_req_type)
      REQ_REG: begin
        q_data.op = OP_REG;
        keep      = slot_ok;
      end
      REQ_UNREG: begin
        q_data.op = OP_UNREG;
        keep      = slot_ok;
      end
      REQ_POLL: begin
        q_data.op = OP_POLL;
        keep      = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // Type 3 and out-of-range (un)register requests are dropped here.
  assign q_push = in_valid && !q_full && keep;

endmodule

@@ rtl/core/mspt_back.sv @@
// Slot engine: executes commands against the slot table and emits events.
module mspt_back #(
  parameter int SLOTS = mspt_pkg::SLOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [mspt_pkg::PER_W-1:0] max_sleep,
  input  logic                       q_empty,
  input  mspt_pkg::cmd_t             q_head,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output mspt_pkg::evt_t             out_evt
);
  import mspt_pkg::*;

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int EW = $bits(ent_t);

  back_state_t      state_r, state_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic [PER_W-1:0] best_r, best_nxt;
  logic [SLOTS-1:0] active_r, active_nxt;
  logic             out_valid_r;
  evt_t             out_r;

  logic             emit;
  evt_t             emit_evt;
  logic             out_free;
  logic             adv;
  logic [AW-1:0]    slot_a;
  logic [AW-1:0]    head_a;

  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  ent_t             ram_wdata, ram_rdata;
  logic [EW-1:0]    ram_rbits;

  logic              div_start, div_done;
  logic [TIME_W-1:0] div_q;
  logic [PER_W-1:0]  div_r;

  logic              due;
  logic [DL_W-1:0]   wait_ms;
  logic [PER_W-1:0]  fire_wait;

  mspt_ram #(
    .WIDTH (EW),
    .DEPTH (SLOTS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rbits)
  );

  assign ram_rdata = ent_t'(ram_rbits);

  mspt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (cmd_r.now - ram_rdata.start),
    .divisor  (ram_rdata.period),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_r)
  );

  assign slot_a    = AW'(cmd_r.slot);
  assign head_a    = AW'(q_head.slot);
  assign out_free  = !out_valid_r || !out_stall;
  assign due       = {1'b0, cmd_r.now} >= ram_rdata.deadline;
  assign wait_ms   = ram_rdata.deadline - {1'b0, cmd_r.now};
  assign fire_wait = ram_rdata.period - div_r;

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    idx_nxt    = idx_r;
    best_nxt   = best_r;
    active_nxt = active_r;
    q_pop      = 1'b0;
    emit       = 1'b0;
    adv        = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = idx_r;
    ram_raddr  = idx_r;
    div_start  = 1'b0;

    emit_evt.slot     = cmd_r.slot;
    emit_evt.kind     = EV_REG;
    emit_evt.ev_time  = cmd_r.now;
    emit_evt.elapsed  = '0;
    emit_evt.sleep_ms = '0;
    emit_evt.last     = 1'b1;

    ram_wdata.start     = cmd_r.now;
    ram_wdata.period    = cmd_r.period;
    ram_wdata.index     = IDX_W'(1);
    ram_wdata.deadline  = {1'b0, cmd_r.now} + DL_W'(cmd_r.period);
    ram_wdata.prev_fire = cmd_r.now;

    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          cmd_nxt = q_head;
          case (q_head.op)
            OP_REG: begin
              state_nxt = ST_REG;
            end
            OP_UNREG: begin
              if (active_r[head_a]) begin
                state_nxt = ST_UNREG_RD;
              end
            end
            OP_POLL: begin
              idx_nxt   = '0;
              best_nxt  = max_sleep;
              state_nxt = ST_POLL_RD;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_REG: begin
        if (out_free) begin
          emit = 1'b1;
          if (!active_r[slot_a]) begin
            ram_we             = 1'b1;
            ram_waddr          = slot_a;
            active_nxt[slot_a] = 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end
      ST_UNREG_RD: begin
        ram_re             = 1'b1;
        ram_raddr          = slot_a;
        active_nxt[slot_a] = 1'b0;
        state_nxt          = ST_UNREG_CHK;
      end
      ST_UNREG_CHK: begin
        emit_evt.kind    = EV_UNREG;
        emit_evt.elapsed = cmd_r.now - ram_rdata.prev_fire;
        if (cmd_r.now > ram_rdata.prev_fire) begin
          if (out_free) begin
            emit      = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_POLL_RD: begin
        if (active_r[idx_r]) begin
          ram_re    = 1'b1;
          state_nxt = ST_POLL_CHK;
        end else begin
          adv = 1'b1;
        end
      end
      ST_POLL_CHK: begin
        if (due) begin
          div_start = 1'b1;
          state_nxt = ST_POLL_DIV;
        end else begin
          if (wait_ms < DL_W'(best_r)) begin
            best_nxt = wait_ms[PER_W-1:0];
          end
          adv = 1'b1;
        end
      end
      ST_POLL_DIV: begin
        if (div_done) begin
          state_nxt = ST_POLL_FIRE;
        end
      end
      ST_POLL_FIRE: begin
        emit_evt.slot    = SLOT_W'(idx_r);
        emit_evt.kind    = EV_FIRE;
        emit_evt.elapsed = cmd_r.now - ram_rdata.prev_fire;
        emit_evt.last    = 1'b0;
        // New deadline is start + (q + 1) * period, which equals now + period - rem.
        ram_wdata.start    = ram_rdata.start;
        ram_wdata.period   = ram_rdata.period;
        ram_wdata.index    = div_q[IDX_W-1:0] + IDX_W'(1);
        ram_wdata.deadline = {1'b0, cmd_r.now} + DL_W'(fire_wait);
        if (out_free) begin
          emit   = 1'b1;
          ram_we = 1'b1;
          if (fire_wait < best_r) begin
            best_nxt = fire_wait;
          end
          adv = 1'b1;
        end
      end
      ST_SUMMARY: begin
        emit_evt.slot     = '0;
        emit_evt.kind     = EV_SLEEP;
        emit_evt.sleep_ms = best_r;
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (adv) begin
      if (idx_r == AW'(SLOTS - 1)) begin
        state_nxt = ST_SUMMARY;
      end else begin
        idx_nxt   = idx_r + 1'b1;
        state_nxt = ST_POLL_RD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      active_r    <= '0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r  <= state_nxt;
      active_r <= active_nxt;
      idx_r    <= idx_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    best_r <= best_nxt;
    if (emit) begin
      out_r <= emit_evt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_evt   = out_r;

endmodule

@@ rtl/core/multi_slot_periodic_timer.sv @@
// Top level of the multi-slot periodic timer.
//
// A table of SLOTS periodic timers driven by requests that each carry the current time in
// milliseconds. A register request always returns one update transaction with elapsed zero and
// arms the slot if it was free; an unregister request frees an armed slot and returns the time
// since its previous fire when that is positive; a poll returns one fire transaction for every
// due slot in ascending slot order, skipping missed periods, followed by a sleep summary that
// gives the time to the nearest deadline capped by the max_sleep register (reset value 200).
// Requests of type 3 and register or unregister requests naming a slot at or beyond SLOTS are
// accepted and produce nothing. Requests enter a two-entry command queue, so the input side keeps
// accepting while the slot engine works or the output side stalls, until the queue is full. The
// costliest part of a poll is a due slot, whose catch-up index comes from the bit-serial
// divider, one quotient bit per cycle over the 48-bit elapsed time, which holds the engine in
// its divide state until the quotient is complete; the rest comes from the slot RAM, which
// takes one registered read per armed slot. Configuration writes are always taken (cfg_ready
// is tied high) and must only be made while the block is idle.
module multi_slot_periodic_timer #(
  parameter int SLOTS = mspt_pkg::SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Request channel.
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_req_type,
  input  logic [mspt_pkg::SLOT_W-1:0] in_slot,
  input  logic [mspt_pkg::PER_W-1:0]  in_period,
  input  logic [mspt_pkg::TIME_W-1:0] in_now,
  // Event channel.
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [mspt_pkg::SLOT_W-1:0] out_slot,
  output logic [1:0]                  out_event_kind,
  output logic [mspt_pkg::TIME_W-1:0] out_event_time,
  output logic [mspt_pkg::TIME_W-1:0] out_elapsed,
  output logic [mspt_pkg::PER_W-1:0]  out_sleep_ms,
  output logic                        out_last,
  // Configuration channel for max_sleep.
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [mspt_pkg::PER_W-1:0]  cfg_data
);
  import mspt_pkg::*;

  // The sleep cap register. A write is one transaction on the configuration channel.
  logic [PER_W-1:0] max_sleep_r;

  // Command queue between the front end and the slot engine.
  logic q_push, q_pop, q_full, q_empty;
  cmd_t q_data, q_head;

  // Event leaving the slot engine's output register.
  evt_t evt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_sleep_r <= MAX_SLEEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      max_sleep_r <= cfg_data;
    end
  end

  // The front end drops type 3 and out-of-range (un)register requests; zero periods become one.
  mspt_front #(
    .SLOTS (SLOTS)
  ) u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .in_slot     (in_slot),
    .in_period   (in_period),
    .in_now      (in_now),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_data)
  );

  mspt_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // The slot engine owns the slot table and the output register.
  mspt_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .max_sleep (max_sleep_r),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_evt   (evt)
  );

  assign out_slot       = evt.slot;
  assign out_event_kind = evt.kind;
  assign out_event_time = evt.ev_time;
  assign out_elapsed    = evt.elapsed;
  assign out_sleep_ms   = evt.sleep_ms;
  assign out_last       = evt.last;

endmodule

@@ rtl/core/mspt_checker.sv @@
// Port-level checks on the multi-slot periodic timer, bound to its top level.
module mspt_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [mspt_pkg::SLOT_W-1:0] out_slot,
  input logic [1:0]                  out_event_kind,
  input logic [mspt_pkg::TIME_W-1:0] out_event_time,
  input logic [mspt_pkg::TIME_W-1:0] out_elapsed,
  input logic [mspt_pkg::PER_W-1:0]  out_sleep_ms,
  input logic                        out_last
);
  import mspt_pkg::*;

  // A stalled event transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_slot) && $stable(out_event_kind)
      && $stable(out_event_time) && $stable(out_elapsed) && $stable(out_sleep_ms)
      && $stable(out_last))
    else $error("stalled event changed");

  // The sleep summary closes a poll and carries no slot or elapsed time.
  a_summary: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == EV_SLEEP |-> out_last && out_slot == '0
      && out_elapsed == '0)
    else $error("malformed sleep summary");

  // A fire is never the final event of a request and never reports a sleep time.
  a_fire: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == EV_FIRE |-> !out_last && out_sleep_ms == '0)
    else $error("malformed fire event");

  // Register and unregister updates stand alone; a register update has zero elapsed time
  // and an unregister update a positive one.
  a_update: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_kind == EV_REG || out_event_kind == EV_UNREG)
      |-> out_last && out_sleep_ms == '0
        && ((out_event_kind == EV_REG) == (out_elapsed == '0)))
    else $error("malformed update event");

endmodule

bind multi_slot_periodic_timer mspt_checker u_mspt_checker (.*);

@@ dv/multi_slot_periodic_timer_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the multi-slot periodic timer, with its own model of the slot table.
module multi_slot_periodic_timer_tb;
  import mspt_pkg::*;

  localparam int NSLOTS = SLOTS_DEF;
  // Request code 3 is accepted by the block and produces nothing.
  localparam logic [1:0] REQ_IGNORED = 2'd3;
  // Idle cycles after the last result before the block may be treated as idle. A request that
  // produces nothing can still sit in the two-entry command queue after the last result.
  localparam int SETTLE_CYCLES = 40;
  // Cycles with no transaction on any channel before the run is declared hung. The longest
  // quiet stretch in a correct run is the divider work of one due slot, stretched by receiver
  // stalls.
  localparam int QUIET_LIMIT = 20000;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [PER_W-1:0] DIRECTED_PERIODS [NSLOTS] =
    '{16'd1, 16'd2, 16'd3, 16'd7, 16'd100, 16'd1000, 16'hFFFF, 16'd0};
  localparam logic [PER_W-1:0] CAP_EXTREMES [3] = '{16'd0, 16'd1, 16'hFFFF};

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [1:0]           in_req_type;
  logic [SLOT_W-1:0]    in_slot;
  logic [PER_W-1:0]     in_period;
  logic [TIME_W-1:0]    in_now;
  logic                 out_valid;
  logic                 out_stall;
  logic [SLOT_W-1:0]    out_slot;
  logic [1:0]           out_event_kind;
  logic [TIME_W-1:0]    out_event_time;
  logic [TIME_W-1:0]    out_elapsed;
  logic [PER_W-1:0]     out_sleep_ms;
  logic                 out_last;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [PER_W-1:0]     cfg_data;

  // Percentages that shape the traffic: chance per cycle that the sender holds back, and
  // chance per cycle that the event receiver stalls.
  int                   idle_pct;
  int                   stall_pct;
  int unsigned          fail_count;
  int unsigned          quiet_cycles;

  // Our own copy of the slot table and the sleep cap. The deadline is one bit wider than the
  // time so that it never wraps; a deadline beyond the 48-bit range can never come due.
  logic                 armed        [NSLOTS];
  logic [TIME_W-1:0]    arm_start    [NSLOTS];
  logic [PER_W-1:0]     arm_period   [NSLOTS];
  logic [IDX_W-1:0]     period_index [NSLOTS];
  logic [DL_W-1:0]      next_due     [NSLOTS];
  logic [TIME_W-1:0]    last_fire    [NSLOTS];
  logic [PER_W-1:0]     sleep_cap;
  // Events that the block owes us, oldest first.
  evt_t                 pending_events [$];

  multi_slot_periodic_timer #(.SLOTS(NSLOTS)) DUT (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The receiver stall is redrawn every cycle, so stalls land on every step of the block's work.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic void queue_event(input logic [SLOT_W-1:0] sl, input evt_kind_t kind,
                                      input logic [TIME_W-1:0] t, input logic [TIME_W-1:0] el,
                                      input logic [PER_W-1:0] slp, input logic lst);
    evt_t ev;
    ev.slot     = sl;
    ev.kind     = kind;
    ev.ev_time  = t;
    ev.elapsed  = el;
    ev.sleep_ms = slp;
    ev.last     = lst;
    pending_events.push_back(ev);
  endfunction

  // Applies one accepted request to the slot table and queues the events it must produce.
  function automatic void predict_events(input logic [1:0] rt, input logic [SLOT_W-1:0] sl,
                                         input logic [PER_W-1:0] per,
                                         input logic [TIME_W-1:0] t);
    logic [63:0] nearest;
    logic [63:0] k;
    logic [63:0] p;
    logic [63:0] gap;
    case (rt)
      REQ_REG: begin
        // The update is always reported; only a free slot gets armed.
        queue_event(sl, EV_REG, t, '0, '0, 1'b1);
        if (!armed[sl]) begin
          armed[sl]        = 1'b1;
          arm_start[sl]    = t;
          arm_period[sl]   = (per == '0) ? PER_W'(1) : per;
          period_index[sl] = IDX_W'(1);
          next_due[sl]     = DL_W'(t) + DL_W'(arm_period[sl]);
          last_fire[sl]    = t;
        end
      end
      REQ_UNREG: begin
        // A free slot is left alone; an armed one reports only if time has moved on.
        if (armed[sl]) begin
          armed[sl] = 1'b0;
          if (t > last_fire[sl]) begin
            queue_event(sl, EV_UNREG, t, t - last_fire[sl], '0, 1'b1);
          end
        end
      end
      REQ_POLL: begin
        nearest = '1;
        for (int i = 0; i < NSLOTS; i++) begin
          if (armed[i]) begin
            if (DL_W'(t) >= next_due[i]) begin
              // Skip every missed period: the new deadline is the first multiple of the
              // period after the start that lies beyond now.
              p = 64'(arm_period[i]);
              k = 64'(t - arm_start[i]) / p + 64'd1;
              queue_event(SLOT_W'(i), EV_FIRE, t, t - last_fire[i], '0, 1'b0);
              period_index[i] = k[IDX_W-1:0];
              next_due[i]     = DL_W'(64'(arm_start[i]) + k * p);
              last_fire[i]    = t;
            end
            gap = 64'(next_due[i]) - 64'(t);
            if (gap < nearest) begin
              nearest = gap;
            end
          end
        end
        if (nearest > 64'(sleep_cap)) begin
          nearest = 64'(sleep_cap);
        end
        queue_event('0, EV_SLEEP, t, '0, nearest[PER_W-1:0], 1'b1);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Sees every transaction at the rising edge: checks events against the oldest expectation,
  // feeds accepted requests and register writes to the model, and feeds the watchdog.
  always @(posedge clk) begin : monitor
    evt_t want;
    if (!rst_n) begin
      for (int i = 0; i < NSLOTS; i++) begin
        armed[i] = 1'b0;
      end
      sleep_cap = MAX_SLEEP_RST;
      pending_events.delete();
      quiet_cycles <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_events.size() == 0) begin
          $error("event with nothing expected: out_slot %0d, out_event_kind %0d",
                 out_slot, out_event_kind);
          fail_count++;
        end else begin
          want = pending_events.pop_front();
          check_field("out_slot", 64'(want.slot), 64'(out_slot));
          check_field("out_event_kind", 64'(want.kind), 64'(out_event_kind));
          check_field("out_event_time", 64'(want.ev_time), 64'(out_event_time));
          check_field("out_elapsed", 64'(want.elapsed), 64'(out_elapsed));
          check_field("out_sleep_ms", 64'(want.sleep_ms), 64'(out_sleep_ms));
          check_field("out_last", 64'(want.last), 64'(out_last));
        end
      end
      if (in_valid && !in_stall) begin
        predict_events(in_req_type, in_slot, in_period, in_now);
      end
      if (cfg_valid && cfg_ready) begin
        sleep_cap = cfg_data;
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // A hung block never lets the run reach its normal end, so this is the timeout.
  initial begin : watchdog
    do @(posedge clk); while (quiet_cycles < QUIET_LIMIT);
    $display("status: fail");
    $finish;
  end

  // Sends one request transaction. Called at a falling edge; returns at the falling edge after
  // acceptance with valid still high, so that back-to-back requests keep valid asserted.
  task automatic send_request(input logic [1:0] rt, input logic [SLOT_W-1:0] sl,
                              input logic [PER_W-1:0] per, input logic [TIME_W-1:0] t);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= rt;
    in_slot     <= sl;
    in_period   <= per;
    in_now      <= t;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Holds the sender off until every expected event has arrived, then lets the block finish
  // any request that produces nothing.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes max_sleep. Only called while the block is idle.
  task automatic write_max_sleep(input logic [PER_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Polling an empty table, arming, re-registering, unregistering with and without an event, and an ignored request.
  task automatic test_registration();
    // Nothing armed yet, so the summary gives the reset cap.
    send_request(REQ_POLL, 3'd0, '0, '0);
    // A zero period is taken as one.
    send_request(REQ_REG, 3'd0, '0, '0);
    // Registering an armed slot reports the update and leaves the slot as it was.
    send_request(REQ_REG, 3'd0, 16'd500, 48'd5);
    // Unregistering a free slot produces nothing.
    send_request(REQ_UNREG, 3'd5, '0, 48'd10);
    // No time has passed since the slot was armed, so it is freed without an event.
    send_request(REQ_UNREG, 3'd0, '0, '0);
    send_request(REQ_REG, 3'd1, 16'd10, 48'd100);
    send_request(REQ_UNREG, 3'd1, '0, 48'd150);
    send_request(REQ_IGNORED, 3'd7, '1, TIME_MAX);
  endtask

  // Polls with every slot armed: catch-up over many missed periods, the full burst of nine
  // events, a deadline beyond the time range, and time running backward.
  task automatic test_poll_catch_up();
    for (int s = 0; s < NSLOTS; s++) begin
      send_request(REQ_REG, SLOT_W'(s), DIRECTED_PERIODS[s], 48'd1000);
    end
    send_request(REQ_POLL, '0, '0, 48'd1000);
    send_request(REQ_POLL, '0, '0, 48'd1000000);
    send_request(REQ_POLL, '0, '0, 48'd1000000);
    send_request(REQ_UNREG, 3'd6, '0, TIME_MAX - 48'd15);
    send_request(REQ_REG, 3'd6, 16'hFFFF, TIME_MAX - 48'd15);
    send_request(REQ_POLL, '0, '0, TIME_MAX);
    send_request(REQ_POLL, '0, '0, '0);
  endtask

  // The cap at its extremes, zero included; every deadline is far away by now.
  task automatic test_sleep_cap();
    for (int j = 0; j < 3; j++) begin
      settle();
      write_max_sleep(CAP_EXTREMES[j]);
      send_request(REQ_POLL, '0, '0, 48'd5);
    end
  endtask

  // Random traffic under one setting of sender idling and receiver stalls. Most requests follow a
  // steadily advancing clock so that slots arm, fire and catch up; the rest are noise with arbitrary times and codes.
  task automatic test_random_traffic(input int idle, input int stall, input int count);
    logic [TIME_W-1:0] clock_ms;
    logic [TIME_W-1:0] rand_now;
    logic [PER_W-1:0]  cap;
    logic [PER_W-1:0]  per;
    logic [SLOT_W-1:0] sl;
    int                r;
    idle_pct  = idle;
    stall_pct = stall;
    settle();
    case ($urandom_range(4))
      0: cap = '0;
      1: cap = PER_W'(1);
      2: cap = '1;
      3: cap = MAX_SLEEP_RST;
      default: cap = PER_W'($urandom_range(65535, 1));
    endcase
    write_max_sleep(cap);
    if ($urandom_range(1) == 1) begin
      clock_ms = TIME_W'({$urandom, $urandom}) >> 1;
    end else begin
      clock_ms = TIME_W'($urandom_range(5000));
    end
    // Start from an empty table so that the clock of this phase governs every slot.
    for (int s = 0; s < NSLOTS; s++) begin
      send_request(REQ_UNREG, SLOT_W'(s), PER_W'($urandom), clock_ms);
    end
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) begin
        settle();
      end
      r        = $urandom_range(99);
      sl       = SLOT_W'($urandom);
      rand_now = TIME_W'({$urandom, $urandom});
      case ($urandom_range(9))
        0:       per = '0;
        1, 2:    per = PER_W'($urandom);
        default: per = PER_W'($urandom_range(40, 1));
      endcase
      if (r < 30) begin
        send_request(REQ_REG, sl, per, clock_ms);
      end else if (r < 45) begin
        send_request(REQ_UNREG, sl, per, clock_ms);
      end else if (r < 85) begin
        send_request(REQ_POLL, sl, per, clock_ms);
      end else if (r < 90) begin
        send_request(REQ_IGNORED, sl, per, rand_now);
      end else if (r < 95) begin
        send_request(($urandom_range(1) == 1) ? REQ_POLL : REQ_UNREG, sl, per, rand_now);
      end else begin
        send_request(REQ_REG, sl, per, clock_ms - TIME_W'($urandom_range(100)));
      end
      clock_ms += TIME_W'($urandom_range(60));
    end
  endtask

  initial begin : main
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_req_type <= REQ_REG;
    in_slot     <= '0;
    in_period   <= '0;
    in_now      <= '0;
    cfg_valid   <= 1'b0;
    cfg_data    <= '0;
    idle_pct     = 0;
    stall_pct    = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_registration();
    test_poll_catch_up();
    test_sleep_cap();
    test_random_traffic(0, 0, 70);
    test_random_traffic(85, 0, 70);
    test_random_traffic(0, 85, 70);
    test_random_traffic(27, 27, 70);
    settle();

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/mspt_pkg.sv
rtl/core/mspt_ram.sv
rtl/core/mspt_div.sv
rtl/core/mspt_fifo.sv
rtl/core/mspt_front.sv
rtl/core/mspt_back.sv
rtl/core/multi_slot_periodic_timer.sv
rtl/core/mspt_checker.sv
dv/multi_slot_periodic_timer_tb.sv
